### hw/rtl/istk_pkg.sv
// Shared constants, codes and interface structs of the integer stack with search.
package istk_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 9;
    localparam int CAP_W  = 9;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 8;

    // Result tdata: data, found_index, count, is_empty, is_full, padded to bytes.
    localparam int M_BITS    = DATA_W + FIDX_W + CNT_W + 2;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [FIDX_W-1:0] fidx;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
    } res_t;

endpackage

### hw/rtl/istk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module istk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/istk_seq.sv
// Operation sequencer: count register, RAM addressing and the search compare unit.
module istk_seq import istk_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [DATA_W-1:0] in_value,
    output logic              in_ready,
    input  logic [CNT_W-1:0]  cap_eff,
    output ram_wr_t           ram_wr,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata,
    output logic              res_valid,
    output res_t              res,
    input  logic              res_take
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [FIDX_W-1:0] fidx_reg, fidx_next;
    logic [CNT_W-1:0]  cnt_dec;
    logic              full_now;
    logic              hit;

    assign cnt_dec  = count_reg - 1'b1;
    assign full_now = count_reg >= cap_eff;
    assign hit      = ram_rdata == key_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        key_next    = key_reg;
        status_next = status_reg;
        data_next   = data_reg;
        fidx_next   = fidx_reg;
        ram_wr.en   = 1'b0;
        ram_wr.addr = count_reg[ADDR_W-1:0];
        ram_wr.data = in_value;
        ram_raddr   = cnt_dec[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    status_next = STAT_OK;
                    data_next   = '0;
                    fidx_next   = '0;
                    key_next    = in_value;
                    addr_next   = cnt_dec[ADDR_W-1:0];
                    state_next  = ST_DONE;
                    case (in_mode)
                        MODE_PUSH: begin
                            if (full_now) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_wr.en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next = cnt_dec;
                                state_next = ST_READ;
                            end
                        end
                        MODE_PEEK: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_SEARCH: begin
                            if (count_reg == '0) begin
                                status_next = STAT_NOTFOUND;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                data_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // rdata holds the entry at addr_reg; fetch the one below speculatively
                ram_raddr = addr_reg - 1'b1;
                if (hit) begin
                    fidx_next  = FIDX_W'(addr_reg);
                    state_next = ST_DONE;
                end else if (addr_reg == '0) begin
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_DONE;
                end else begin
                    addr_next = ram_raddr;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        fidx_reg   <= fidx_next;
    end

    assign in_ready   = state_reg == ST_IDLE;
    assign res_valid  = state_reg == ST_DONE;
    assign res.status = status_reg;
    assign res.data   = data_reg;
    assign res.fidx   = fidx_reg;
    assign res.count  = count_reg;
    assign res.empty  = count_reg == '0;
    assign res.full   = full_now;

endmodule

### hw/rtl/int_stack_with_search_top.sv
// Top level of the integer stack with search: capacity register, RAM, sequencer, output word.
//
// LIFO stack of 256 signed 32-bit entries with a programmable capacity, taking one
// request word at a time on the s_ stream and returning one result word on the m_
// stream. The block handles one request at a time: s_tready is high only while the
// sequencer is idle. From acceptance to the result word showing on m_tvalid, push,
// clear and unused modes go straight to the result, pop and peek pass through one
// registered read of the stack RAM, and search stops at the first hit or, on a miss,
// after all count entries, because the scan walks the single RAM read port one
// entry per cycle from the top down. The next request is taken in the cycle after
// the result word moves into the output register. Capacity above 256 saturates at
// 256; lowering it below the current count keeps the entries and only makes push
// report full. Write the capacity only while the block is idle.
module int_stack_with_search_top import istk_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // capacity register write port
    input  logic                 cfg_wen,
    input  logic [CAP_W-1:0]     cfg_wdata,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // [31:0] value
    input  logic [MODE_W-1:0]    s_tuser,    // [2:0] mode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [31:0] data, [39:32] found_index,
                                             // [48:40] count, [49] is_empty,
                                             // [50] is_full, rest zero
    output logic [STAT_W-1:0]    m_tuser     // [1:0] status
);

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  cap_eff;
    ram_wr_t           ram_wr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    res_t              res;
    logic              res_take;
    logic              m_tvalid_reg;
    res_t              m_res_reg;

    // Hold the capacity; clamp it to the stack depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(DEPTH);
        end else if (cfg_wen) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign cap_eff = (cap_reg > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);

    istk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    istk_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_value  (s_tdata),
        .in_ready  (s_tready),
        .cap_eff   (cap_eff),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Advance a finished result into the output word whenever that word is free or leaving.
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{(M_TDATA_W - M_BITS){1'b0}},
                       m_res_reg.full, m_res_reg.empty, m_res_reg.count,
                       m_res_reg.fidx, m_res_reg.data};

    // A RAM write only comes from an accepted push.
    a_write_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.en |-> (s_tvalid && s_tready && s_tuser == MODE_PUSH))
        else $error("stack write without an accepted push");

    // The count never goes past the stack depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.count <= CNT_W'(DEPTH)))
        else $error("stack count beyond depth");

    // No new request is taken while a result is pending in the sequencer.
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && res_valid))
        else $error("request accepted while a result is pending");

    // A result moved into the output word is shown in the next cycle.
    a_take_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |=> m_tvalid)
        else $error("taken result not presented on the output");

endmodule

### bench/int_stack_with_search_top_tb.sv
// Self-checking bench for the integer stack with search: directed table, random phases, scoreboard.
module int_stack_with_search_top_tb;
    import istk_pkg::*;

    // Bit offsets of the result fields inside m_tdata
    localparam int OFS_FIDX  = DATA_W;
    localparam int OFS_CNT   = OFS_FIDX + FIDX_W;
    localparam int OFS_EMPTY = OFS_CNT + CNT_W;
    localparam int OFS_FULL  = OFS_EMPTY + 1;

    // Mode codes the block treats as no-ops
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    localparam int LONG_HOLD_CYCLES = 200;
    localparam int MAX_REPORTS      = 10;

    typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;    // request value, or new capacity on ROW_CAP
        logic              known;    // expected word typed in below
        res_t              res;
    } row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic [MODE_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // Shadow stack: entries, fill level and capacity register
    logic [DATA_W-1:0] stack_mem [DEPTH];
    int unsigned       stack_count;
    logic [CAP_W-1:0]  stack_cap;

    res_t pending_results [$];
    row_t plan [$];
    int   n_bad         = 0;
    int   burst_left    = 0;
    int   rx_hold_cycles = 0;

    int_stack_with_search_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one request to the shadow stack and return the word the block must produce.
    function automatic res_t stack_step(input logic [MODE_W-1:0] mode,
                                        input logic [DATA_W-1:0] value);
        res_t        r;
        int unsigned lim;
        int unsigned idx;
        r   = '0;
        lim = (stack_cap > DEPTH) ? DEPTH : stack_cap;   // capacity saturates at DEPTH
        case (mode)
            MODE_PUSH: begin
                if (stack_count >= lim) begin
                    r.status = STAT_FULL;
                end else begin
                    stack_mem[stack_count] = value;
                    stack_count++;
                end
            end
            MODE_POP: begin
                if (stack_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    stack_count--;
                    r.data = stack_mem[stack_count];
                end
            end
            MODE_PEEK: begin
                if (stack_count == 0)
                    r.status = STAT_EMPTY;
                else
                    r.data = stack_mem[stack_count - 1];
            end
            MODE_CLEAR: begin
                stack_count = 0;
            end
            MODE_SEARCH: begin
                // scan from the top down, stop at the first equal entry
                r.status = STAT_NOTFOUND;
                idx = stack_count;
                while (idx > 0 && r.status == STAT_NOTFOUND) begin
                    idx--;
                    if (stack_mem[idx] == value) begin
                        r.status = STAT_OK;
                        r.fidx   = idx[FIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.count = stack_count[CNT_W-1:0];
        r.empty = (stack_count == 0);
        r.full  = (stack_count >= lim);
        return r;
    endfunction

    function automatic res_t mk_res(input logic [STAT_W-1:0] st, input logic [DATA_W-1:0] d,
                                    input logic [FIDX_W-1:0] fi, input logic [CNT_W-1:0] c,
                                    input logic e, input logic f);
        res_t r;
        r.status = st;
        r.data   = d;
        r.fidx   = fi;
        r.count  = c;
        r.empty  = e;
        r.full   = f;
        return r;
    endfunction

    task automatic add_word(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        plan.push_back({ROW_WORD, mode, value, 1'b0, res_t'('0)});
    endtask

    task automatic add_known(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                             input res_t res);
        plan.push_back({ROW_WORD, mode, value, 1'b1, res});
    endtask

    task automatic add_cap(input logic [CAP_W-1:0] cap);
        plan.push_back({ROW_CAP, MODE_PUSH, DATA_W'(cap), 1'b0, res_t'('0)});
    endtask

    // Offer one request word; predict its result at the edge that accepts it.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                             input logic known, input res_t known_res);
        res_t r;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = stack_step(mode, value);
        pending_results.push_back(known ? known_res : r);
        burst_left--;
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    // Drop valid if a burst is still open.
    task automatic idle_sender();
        if (burst_left != 0) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Hold the sender until every expected word is back, then let the block settle.
    task automatic settle();
        idle_sender();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_wdata <= cap;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        stack_cap = cap;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            4, 5:    return DATA_W'($urandom_range(0, 7));   // small pool makes duplicates
            default: return $urandom;
        endcase
    endfunction

    // One random phase: new capacity, then n requests drawn by the given mode weights (percent).
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int w_push,
                             input int w_pop, input int w_peek, input int w_clear,
                             input int w_search, input logic long_hold);
        int                roll;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
        settle();
        write_capacity(cap);
        if (long_hold) rx_hold_cycles = LONG_HOLD_CYCLES;
        for (int k = 0; k < n; k++) begin
            roll  = $urandom_range(0, 99);
            value = pick_value();
            if (roll < w_push)
                mode = MODE_PUSH;
            else if (roll < w_push + w_pop)
                mode = MODE_POP;
            else if (roll < w_push + w_pop + w_peek)
                mode = MODE_PEEK;
            else if (roll < w_push + w_pop + w_peek + w_clear)
                mode = MODE_CLEAR;
            else if (roll < w_push + w_pop + w_peek + w_clear + w_search)
                mode = MODE_SEARCH;
            else
                mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            // most search keys hit a live entry
            if (mode == MODE_SEARCH && stack_count != 0 && $urandom_range(0, 99) < 60)
                value = stack_mem[$urandom_range(0, stack_count - 1)];
            send_word(mode, value, 1'b0, '0);
        end
    endtask

    // Receiver: short ready/stall runs, free-running stretches, and one long hold on request.
    initial begin : rx_pattern
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    // Scoreboard: compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin : result_check
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.data   = m_tdata[DATA_W-1:0];
            got.fidx   = m_tdata[OFS_FIDX +: FIDX_W];
            got.count  = m_tdata[OFS_CNT +: CNT_W];
            got.empty  = m_tdata[OFS_EMPTY];
            got.full   = m_tdata[OFS_FULL];
            if (pending_results.size() == 0) begin
                if (n_bad < MAX_REPORTS)
                    $display("%0t: result word with nothing expected (status %0d data %h)",
                             $time, got.status, got.data);
                n_bad++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.data !== want.data ||
                    got.fidx !== want.fidx || got.count !== want.count ||
                    got.empty !== want.empty || got.full !== want.full) begin
                    if (n_bad < MAX_REPORTS)
                        $display("%0t: mismatch exp/act: status %0d/%0d data %h/%h ",
                                 $time, want.status, got.status, want.data, got.data,
                                 "index %0d/%0d count %0d/%0d empty %0b/%0b full %0b/%0b",
                                 want.fidx, got.fidx, want.count, got.count,
                                 want.empty, got.empty, want.full, got.full);
                    n_bad++;
                end
            end
        end
    end

    initial begin : stimulus
        stack_count = 0;
        stack_cap   = CAP_W'(DEPTH);

        // Directed table: empty stack, extreme words, every mode, capacity corner cases
        add_known(MODE_POP,    32'h0,         mk_res(STAT_EMPTY,    '0, '0, 9'd0, 1'b1, 1'b0));
        add_known(MODE_PEEK,   32'h0,         mk_res(STAT_EMPTY,    '0, '0, 9'd0, 1'b1, 1'b0));
        add_known(MODE_SEARCH, 32'h0,         mk_res(STAT_NOTFOUND, '0, '0, 9'd0, 1'b1, 1'b0));
        add_known(MODE_PUSH,   32'h7FFF_FFFF, mk_res(STAT_OK,       '0, '0, 9'd1, 1'b0, 1'b0));
        add_known(MODE_PUSH,   32'h8000_0000, mk_res(STAT_OK,       '0, '0, 9'd2, 1'b0, 1'b0));
        add_word (MODE_PUSH,   32'h0);
        add_word (MODE_PUSH,   32'hFFFF_FFFF);
        add_word (MODE_PEEK,   32'h0);
        add_known(MODE_SEARCH, 32'h7FFF_FFFF, mk_res(STAT_OK,       '0, '0, 9'd4, 1'b0, 1'b0));
        add_word (MODE_SEARCH, 32'h8000_0000);
        add_known(MODE_SEARCH, 32'h1234_5678, mk_res(STAT_NOTFOUND, '0, '0, 9'd4, 1'b0, 1'b0));
        add_known(MODE_UNUSED_LO, 32'hFFFF_FFFF, mk_res(STAT_OK,    '0, '0, 9'd4, 1'b0, 1'b0));
        add_known(MODE_UNUSED_HI, 32'h0,      mk_res(STAT_OK,       '0, '0, 9'd4, 1'b0, 1'b0));
        add_word (MODE_POP,    32'h0);
        // capacity dropped below the fill level: entries stay, push reports full
        add_cap  (9'd2);
        add_known(MODE_PUSH,   32'h1,         mk_res(STAT_FULL,     '0, '0, 9'd3, 1'b0, 1'b1));
        add_word (MODE_SEARCH, 32'h0);
        add_word (MODE_POP,    32'h0);
        add_word (MODE_POP,    32'h0);
        add_known(MODE_CLEAR,  32'h0,         mk_res(STAT_OK,       '0, '0, 9'd0, 1'b1, 1'b0));
        // zero capacity: empty and full at once
        add_cap  (9'd0);
        add_known(MODE_PUSH,   32'h5,         mk_res(STAT_FULL,     '0, '0, 9'd0, 1'b1, 1'b1));
        add_known(MODE_POP,    32'h0,         mk_res(STAT_EMPTY,    '0, '0, 9'd0, 1'b1, 1'b1));
        // capacity above DEPTH saturates
        add_cap  (9'd511);
        add_word (MODE_PUSH,   32'h6);
        add_word (MODE_PEEK,   32'h0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CAP) begin
                settle();
                write_capacity(plan[i].value[CAP_W-1:0]);
            end else begin
                send_word(plan[i].mode, plan[i].value, plan[i].known, plan[i].res);
            end
        end

        //        cap      n   push pop peek clr srch hold
        run_phase(9'd5,   100, 35,  25, 10,  3,  22,  1'b0);
        run_phase(9'd511, 300, 86,  3,  3,   0,  6,   1'b0);  // fill up to DEPTH
        run_phase(9'd16,  80,  30,  35, 10,  0,  20,  1'b1);  // far below fill level
        run_phase(9'd0,   40,  20,  40, 10,  5,  20,  1'b0);
        run_phase(9'd1,   60,  40,  25, 10,  3,  17,  1'b0);
        run_phase(9'd300, 80,  40,  25, 10,  3,  17,  1'b0);
        run_phase(9'd256, 40,  40,  25, 10,  3,  17,  1'b0);

        settle();
        repeat (12) @(posedge aclk);
        if (n_bad == 0)
            $display("int_stack_with_search_top_tb OK");
        else
            $display("int_stack_with_search_top_tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #24_000_000;
        $display("int_stack_with_search_top_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/istk_pkg.sv
hw/rtl/istk_ram.sv
hw/rtl/istk_seq.sv
hw/rtl/int_stack_with_search_top.sv
bench/int_stack_with_search_top_tb.sv
